>>> sv/bba_pkg.sv
// Package for the buddy block allocator: sizes, opcodes and result type.
// Used by all allocator modules.
package bba_pkg;
  localparam int MinOrder  = 5;
  localparam int MaxOrder  = 16;
  localparam int UnitBits  = MaxOrder - MinOrder;
  localparam int NumUnits  = 1 << UnitBits;
  localparam int NumOrders = MaxOrder + 1;
  localparam int OrdBits   = 5;
  localparam int HdrBytes  = 12;

  typedef logic [UnitBits-1:0] unit_t;
  typedef logic [OrdBits-1:0]  ord_t;

  typedef enum logic [1:0] {
    OP_ALLOC  = 2'd0,
    OP_FREE   = 2'd1,
    OP_LOOKUP = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [31:0] request_bytes;
    logic [31:0] item_id;
  } req_t;

  typedef struct packed {
    logic        status;
    logic [31:0] alloc_id;
    logic [15:0] payload_offset;
    logic [16:0] asked_bytes;
  } rsp_t;

  function automatic ord_t top_of(logic [16:0] bytes);
    ord_t o;
    o = ord_t'(MinOrder);
    for (int i = MinOrder; i < MaxOrder; i++) begin
      if ((18'd1 << (i + 1)) <= {1'b0, bytes}) o = ord_t'(i + 1);
    end
    return o;
  endfunction
endpackage

>>> sv/bba_if.sv
// Valid/ready channel carrying one payload beat.
// Depends on nothing; payload type is a parameter.
interface bba_if #(parameter type payload_t = logic) (input logic clk);
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> sv/bba_headers.sv
// Header and free link store, one entry per minimum-size unit.
// Depends on bba_pkg.
module bba_headers (
  input  logic                   clk,
  input  logic                   we,
  input  bba_pkg::unit_t         waddr,
  input  logic [31:0]            wowner,
  input  bba_pkg::ord_t          word,
  input  logic [16:0]            wreq,
  input  logic                   lwe,
  input  bba_pkg::unit_t         lwaddr,
  input  bba_pkg::unit_t         lwdata,
  input  logic                   lwvalid,
  input  bba_pkg::unit_t         raddr,
  output logic [31:0]            rowner,
  output bba_pkg::ord_t          rord,
  output logic [16:0]            rreq,
  output bba_pkg::unit_t         rnext,
  output logic                   rnvalid
);
  import bba_pkg::*;
  logic [31:0] owner_mem [NumUnits];
  ord_t        ord_mem   [NumUnits];
  logic [16:0] req_mem   [NumUnits];
  logic [UnitBits:0] link_mem [NumUnits];

  always_ff @(posedge clk) begin
    if (we) begin
      owner_mem[waddr] <= wowner;
      ord_mem[waddr]   <= word;
      req_mem[waddr]   <= wreq;
    end
    if (lwe) link_mem[lwaddr] <= {lwvalid, lwdata};
    rowner <= owner_mem[raddr];
    rord   <= ord_mem[raddr];
    rreq   <= req_mem[raddr];
    {rnvalid, rnext} <= link_mem[raddr];
  end
endmodule

>>> sv/bba_seq.sv
// Sequencer: allocate search and split, header walk for free and lookup.
// Depends on bba_pkg and bba_headers.
module bba_seq (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_we,
  input  logic [16:0]   cfg_data,
  input  logic          start,
  input  bba_pkg::req_t req,
  output logic          busy,
  output logic          done,
  output bba_pkg::rsp_t rsp
);
  import bba_pkg::*;
  typedef enum logic [3:0] {
    S_IDLE, S_INIT, S_SCAN, S_SPLIT_RD, S_SPLIT_WT, S_SPLIT_R, S_SPLIT_L,
    S_POP_RD, S_POP_WT, S_POP, S_WALK_RD, S_WALK_WT, S_WALK, S_DONE
  } state_t;

  state_t      state;
  ord_t        top_order, want, cur_ord;
  logic [31:0] next_id;
  unit_t       heads [NumOrders];
  logic [NumOrders-1:0] hvalid;
  req_t        r;
  logic [UnitBits:0] cur;
  unit_t       u;

  logic        we, lwe, lwvalid;
  unit_t       waddr, lwaddr, lwdata, raddr, rnext;
  logic [31:0] wowner, rowner;
  ord_t        word, rord;
  logic [16:0] wreq, rreq;
  logic        rnvalid;
  unit_t       half;
  logic [UnitBits:0] walk_end;
  logic [31:0] id_inc;

  assign half     = unit_t'((UnitBits+1)'(1) << (cur_ord - ord_t'(MinOrder + 1)));
  assign walk_end = (UnitBits+1)'(1) << (top_order - ord_t'(MinOrder));
  assign id_inc   = (next_id + 32'd1 == 32'd0) ? 32'd1 : next_id + 32'd1;
  assign busy     = state != S_IDLE;

  bba_headers u_hdr (
    .clk, .we, .waddr, .wowner, .word, .wreq, .lwe, .lwaddr, .lwdata, .lwvalid,
    .raddr, .rowner, .rord, .rreq, .rnext, .rnvalid
  );

  always_comb begin
    we = 1'b0; waddr = u; wowner = '0; word = cur_ord; wreq = '0;
    lwe = 1'b0; lwaddr = u; lwdata = heads[cur_ord]; lwvalid = hvalid[cur_ord];
    raddr = (state == S_WALK_RD || state == S_WALK_WT) ? unit_t'(cur) : heads[cur_ord];
    unique case (state)
      S_INIT: begin
        we = 1'b1; waddr = '0; word = top_order;
        lwe = 1'b1; lwaddr = '0; lwvalid = 1'b0;
      end
      S_SPLIT_R: begin
        we = 1'b1; waddr = u + half; word = cur_ord - ord_t'(1);
        lwe = 1'b1; lwaddr = u + half;
        lwdata = heads[cur_ord - ord_t'(1)]; lwvalid = hvalid[cur_ord - ord_t'(1)];
      end
      S_SPLIT_L: begin
        we = 1'b1; word = cur_ord - ord_t'(1);
        lwe = 1'b1; lwdata = u + half; lwvalid = 1'b1;
      end
      S_POP: begin
        we = 1'b1; wowner = next_id; word = want;
        wreq = r.request_bytes[16:0];
      end
      S_WALK: begin
        if (rowner == r.item_id && r.opcode == OP_FREE) begin
          we = 1'b1; waddr = unit_t'(cur); word = rord;
          lwe = 1'b1; lwaddr = unit_t'(cur);
          lwdata = heads[rord]; lwvalid = hvalid[rord];
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      state <= S_INIT; top_order <= ord_t'(MaxOrder);
      hvalid <= '0; next_id <= 32'd1;
    end else if (cfg_we) begin
      state <= S_INIT; top_order <= top_of(cfg_data);
      hvalid <= '0; next_id <= 32'd1;
    end else begin
      unique case (state)
        S_INIT: begin
          heads[top_order] <= '0; hvalid[top_order] <= 1'b1;
          state <= S_IDLE;
        end
        S_IDLE: begin
          if (start) begin
            r <= req; rsp <= '{status: 1'b1, default: '0};
            want <= ord_t'(MinOrder); cur <= '0;
            unique case (op_t'(req.opcode))
              OP_ALLOC:  state <= (req.request_bytes == 0) ? S_DONE : S_SCAN;
              OP_FREE, OP_LOOKUP: state <= (req.item_id == 0) ? S_DONE : S_WALK_RD;
              default:   state <= S_DONE;
            endcase
          end
        end
        S_SCAN: begin
          if (want > top_order) state <= S_DONE;
          else if ((33'd1 << want) < {1'b0, r.request_bytes}) want <= want + ord_t'(1);
          else begin
            cur_ord <= want; state <= S_POP_RD;
          end
        end
        S_POP_RD: begin
          if (cur_ord > top_order) state <= S_DONE;
          else if (!hvalid[cur_ord]) cur_ord <= cur_ord + ord_t'(1);
          else state <= (cur_ord == want) ? S_POP_WT : S_SPLIT_WT;
        end
        S_SPLIT_WT: begin
          u <= heads[cur_ord]; state <= S_SPLIT_RD;
        end
        S_SPLIT_RD: begin
          heads[cur_ord] <= rnext; hvalid[cur_ord] <= rnvalid;
          state <= S_SPLIT_R;
        end
        S_SPLIT_R: begin
          heads[cur_ord - ord_t'(1)] <= u + half;
          hvalid[cur_ord - ord_t'(1)] <= 1'b1;
          state <= S_SPLIT_L;
        end
        S_SPLIT_L: begin
          heads[cur_ord - ord_t'(1)] <= u;
          cur_ord <= cur_ord - ord_t'(1);
          state <= (cur_ord - ord_t'(1) == want) ? S_POP_WT : S_SPLIT_WT;
        end
        S_POP_WT: begin
          u <= heads[cur_ord]; state <= S_POP;
        end
        S_POP: begin
          heads[want] <= rnext; hvalid[want] <= rnvalid;
          rsp.status <= 1'b0; rsp.alloc_id <= next_id;
          next_id <= id_inc; state <= S_DONE;
        end
        S_WALK_RD: state <= (cur < walk_end) ? S_WALK_WT : S_DONE;
        S_WALK_WT: state <= S_WALK;
        S_WALK: begin
          if (rowner == r.item_id) begin
            rsp.status <= 1'b0;
            if (r.opcode == OP_FREE) begin
              heads[rord] <= unit_t'(cur); hvalid[rord] <= 1'b1;
            end else begin
              rsp.payload_offset <= 16'((32'(cur) << MinOrder) + HdrBytes);
              rsp.asked_bytes <= rreq;
            end
            state <= S_DONE;
          end else if (rord < ord_t'(MinOrder) || rord > top_order) begin
            state <= S_DONE;
          end else begin
            cur <= cur + ((UnitBits+1)'(1) << (rord - ord_t'(MinOrder)));
            state <= S_WALK_RD;
          end
        end
        S_DONE: begin
          done <= 1'b1; state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

>>> sv/buddy_block_allocator.sv
// Buddy block allocator over a pool of up to 64 KiB in 32-byte units.
// Channels: cmd (opcode, request_bytes, item_id) in, rsp (status, alloc_id,
// payload_offset, asked_bytes) out, cfg carries pool_bytes.
// One command at a time; cmd is not ready while a command is in flight.
// Allocate: finds the fitting order w, then splits blocks down from the first
// free order i above w until a block of order w can be taken.
// Free/lookup: walks the block headers in address order, at most 2048 for
// a pool split into minimum blocks, each read through the header memory.
// The result sits in an output register; the next command is taken once that
// beat leaves, so a stalled receiver stalls cmd.
// Reset (and any cfg write) rebuilds the root free block in the S_INIT state;
// pool_bytes resets to 65536 and identifiers restart at 1.
// Depends on bba_pkg, bba_if and bba_seq.
module buddy_block_allocator (
  input logic clk,
  input logic rst,
  bba_if.sink   cmd,
  bba_if.sink   cfg,
  bba_if.source rsp
);
  import bba_pkg::*;
  logic busy, done, start, full;
  rsp_t res;

  assign cfg.ready = !busy;
  assign start     = cmd.valid && cmd.ready;
  assign cmd.ready = !busy && !done && !(full && !rsp.ready) && !cfg.valid;

  bba_seq u_seq (
    .clk, .rst, .cfg_we(cfg.valid && cfg.ready), .cfg_data(cfg.data),
    .start, .req(cmd.data), .busy, .done, .rsp(res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else begin
      if (done) full <= 1'b1;
      else if (rsp.ready) full <= 1'b0;
    end
    if (done) rsp.data <= res;
  end
  assign rsp.valid = full;
endmodule
